[rtl/core/posterize_edge_cartoon_macros.svh]
// Assertion macros used by the checker file of posterize_edge_cartoon.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef POSTERIZE_EDGE_CARTOON_MACROS_SVH
`define POSTERIZE_EDGE_CARTOON_MACROS_SVH

// next-cycle check that is also live while reset is asserted
`define PCE_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error("%m: lbl");

// next-cycle check that is held off during reset
`define PCE_CHK_NEXT_RUN(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: lbl");

`endif

[rtl/core/pce_pkg.sv]
// Shared types and constants of the posterize/outline cartoon filter.
// No dependencies.
`timescale 1ns / 1ps
package pce_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_EDGE   = 30;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = $clog2(MAX_EDGE);
  localparam int ADDR_W     = SLOT_W + COL_W;
  localparam int RING_DEPTH = MAX_EDGE * MAX_WIDTH;
  localparam int PIX_W      = 24;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [2:0] REG_LEVEL_STEP    = 3'd0;
  localparam logic [2:0] REG_EDGE_DISTANCE = 3'd1;
  localparam logic [2:0] REG_MONO_MODE     = 3'd2;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd3;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd4;

  localparam logic [PIX_W-1:0] PIX_WHITE = 24'hFFFFFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 24'h000000;

  // effective (clamped) configuration
  typedef struct packed {
    logic [7:0]  step;
    logic [4:0]  edge_d;
    logic        mono;
    logic [10:0] width;
    logic [11:0] height;
  } cfg_t;

  // one unit of work for the back end
  typedef struct packed {
    logic              flush;
    logic              emit;
    logic              inner;
    logic              last;
    logic [ADDR_W-1:0] addr_old;
    logic [ADDR_W-1:0] addr_right;
    logic [PIX_W-1:0]  pix;
  } cmd_t;
endpackage

[rtl/core/pce_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module pce_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/pce_fifo.sv]
// Short command queue between front and back end.
// Depends on pce_pkg.
`timescale 1ns / 1ps
module pce_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pce_pkg::cmd_t push_cmd,
  input  logic          pop,
  output pce_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  pce_pkg::cmd_t                   slot_r [pce_pkg::FIFO_DEPTH];
  logic [pce_pkg::FIFO_PTR_W-1:0]  wp_r, rp_r;
  logic [pce_pkg::FIFO_PTR_W:0]    cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (pce_pkg::FIFO_PTR_W+1)'(pce_pkg::FIFO_DEPTH));
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

[rtl/core/pce_front.sv]
// Front end: frame position tracking and classification of input transfers.
// Depends on pce_pkg.
`timescale 1ns / 1ps
module pce_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pce_pkg::cfg_t             cfg,
  input  logic                      acc,
  input  logic                      kind,
  input  logic [pce_pkg::PIX_W-1:0] pix,
  output logic                      push,
  output pce_pkg::cmd_t             cmd
);
  logic [pce_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [15:0]                row_r, row_nxt;
  logic [pce_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [14:0]                fl_r, fl_nxt;

  logic [15:0]                h16, pend;
  logic [4:0]                 rows;
  logic                       draining, last, restart;
  logic [pce_pkg::COL_W-1:0]  bx, ax;
  logic [15:0]                by, ay;
  logic [pce_pkg::SLOT_W-1:0] bs, as_;
  logic [10:0]                xe;

  assign h16      = {4'b0, cfg.height};
  assign draining = (row_r >= h16);
  assign rows     = (cfg.height < {7'b0, cfg.edge_d}) ? cfg.height[4:0] : cfg.edge_d;
  assign pend     = {11'b0, rows} * {5'b0, cfg.width};
  assign last     = ({1'b0, fl_r} + 16'd1) >= pend;
  assign restart  = draining;

  // base position: a pixel during drain starts a new frame
  always_comb begin
    if (kind) begin
      bx = col_r;
      by = row_r;
      bs = slot_r;
    end else begin
      bx = restart ? '0 : col_r;
      by = restart ? '0 : row_r;
      bs = restart ? '0 : slot_r;
    end
  end

  // one column step
  always_comb begin
    ax  = bx + 1'b1;
    ay  = by;
    as_ = bs;
    if (({1'b0, bx} + 11'd1) >= cfg.width) begin
      ax  = '0;
      ay  = by + 16'd1;
      as_ = (({1'b0, bs} + 6'd1) >= {1'b0, cfg.edge_d}) ? '0 : bs + 1'b1;
    end
  end

  assign xe = {1'b0, bx} + {6'b0, cfg.edge_d};

  always_comb begin
    cmd.flush      = kind;
    cmd.emit       = kind ? 1'b1 : (by >= {11'b0, cfg.edge_d});
    cmd.inner      = !kind && (by >= {10'b0, cfg.edge_d, 1'b0})
                     && ({1'b0, bx} >= {6'b0, cfg.edge_d})
                     && ((xe + 11'd1) <= cfg.width);
    cmd.last       = kind && last;
    cmd.addr_old   = {bs, bx};
    cmd.addr_right = {bs, xe[pce_pkg::COL_W-1:0]};
    cmd.pix        = pix;
    push           = acc && (!kind || draining);
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    fl_nxt   = fl_r;
    if (acc) begin
      if (kind) begin
        if (draining) begin
          if (last) begin
            col_nxt  = '0;
            row_nxt  = '0;
            slot_nxt = '0;
            fl_nxt   = '0;
          end else begin
            fl_nxt   = fl_r + 15'd1;
            col_nxt  = ax;
            row_nxt  = ay;
            slot_nxt = as_;
          end
        end
      end else begin
        col_nxt  = ax;
        row_nxt  = ay;
        slot_nxt = as_;
        fl_nxt   = restart ? '0 : fl_r;
        if (ay >= h16) begin
          fl_nxt = '0;
          if (cfg.height < {7'b0, cfg.edge_d}) slot_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      fl_r   <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      fl_r   <= fl_nxt;
    end
  end
endmodule

[rtl/core/pce_back.sv]
// Back end: per-channel quantizer, line store access, outline decision, output register.
// Depends on pce_pkg and pce_ram.
`timescale 1ns / 1ps
module pce_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pce_pkg::cfg_t             cfg,
  input  pce_pkg::cmd_t             head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pce_pkg::PIX_W-1:0] out_data,
  output logic                      out_last
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_CALC = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  pce_pkg::cmd_t             cmd_r;
  logic [2:0]                cnt_r;
  logic [7:0]                dvd_r [3];
  logic [7:0]                rem_r [3];
  logic [7:0]                quo_r [3];
  logic [7:0]                dvd_nxt [3];
  logic [7:0]                rem_nxt [3];
  logic [7:0]                quo_nxt [3];
  logic [pce_pkg::PIX_W-1:0] rd_old, rd_right, qpix, res;
  logic                      out_valid_r, out_free, done;
  logic [pce_pkg::PIX_W-1:0] out_data_r;
  logic                      out_last_r;

  assign pop = (state_r == ST_IDLE) && !empty;

  pce_ram #(.WIDTH(pce_pkg::PIX_W), .DEPTH(pce_pkg::RING_DEPTH)) u_ram_old (
    .clk(clk), .we(done && !cmd_r.flush && (state_r == ST_CALC)),
    .waddr(cmd_r.addr_old), .wdata(qpix),
    .re(pop), .raddr(head.addr_old), .rdata(rd_old)
  );

  pce_ram #(.WIDTH(pce_pkg::PIX_W), .DEPTH(pce_pkg::RING_DEPTH)) u_ram_right (
    .clk(clk), .we(done && !cmd_r.flush && (state_r == ST_CALC)),
    .waddr(cmd_r.addr_old), .wdata(qpix),
    .re(pop), .raddr(head.addr_right), .rdata(rd_right)
  );

  // restoring divide, one quotient bit per cycle, three lanes
  always_comb begin
    logic [8:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh         = {rem_r[i], dvd_r[i][7]};
      dvd_nxt[i] = {dvd_r[i][6:0], 1'b0};
      if (sh >= {1'b0, cfg.step}) begin
        rem_nxt[i] = 8'(sh - {1'b0, cfg.step});
        quo_nxt[i] = {quo_r[i][6:0], 1'b1};
      end else begin
        rem_nxt[i] = sh[7:0];
        quo_nxt[i] = {quo_r[i][6:0], 1'b0};
      end
    end
  end

  // round half to even, rebuilt as v - r (+ step), saturated
  always_comb begin
    logic [8:0] r2, y9;
    logic       up;
    logic [7:0] v;
    for (int i = 0; i < 3; i++) begin
      v  = cmd_r.pix[8*i +: 8];
      r2 = {rem_r[i], 1'b0};
      up = (r2 > {1'b0, cfg.step}) || ((r2 == {1'b0, cfg.step}) && quo_r[i][0]);
      y9 = {1'b0, v - rem_r[i]} + (up ? {1'b0, cfg.step} : 9'd0);
      qpix[8*i +: 8] = y9[8] ? 8'hFF : y9[7:0];
    end
  end

  always_comb begin
    res = rd_old;
    if (cmd_r.inner) begin
      if ((rd_old != rd_right) || (qpix != rd_old)) res = pce_pkg::PIX_BLACK;
      else if (cfg.mono)                            res = pce_pkg::PIX_WHITE;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign done     = !cmd_r.emit || out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pop) state_nxt = head.flush ? ST_CALC : ST_DIV;
      ST_DIV:  if (cnt_r == 3'd7) state_nxt = ST_CALC;
      ST_CALC: if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head;
      for (int i = 0; i < 3; i++) begin
        dvd_r[i] <= head.pix[8*i +: 8];
        rem_r[i] <= '0;
        quo_r[i] <= '0;
      end
    end else if (state_r == ST_DIV) begin
      for (int i = 0; i < 3; i++) begin
        dvd_r[i] <= dvd_nxt[i];
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
      end
    end
    if ((state_r == ST_CALC) && cmd_r.emit && out_free) begin
      out_data_r <= res;
      out_last_r <= cmd_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= (state_r == ST_DIV) ? cnt_r + 3'd1 : 3'd0;
      if ((state_r == ST_CALC) && cmd_r.emit && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                                 out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
endmodule

[rtl/core/posterize_edge_cartoon.sv]
// Posterize-and-outline cartoon filter for a raster-order BGR pixel stream.
// Each channel is quantized to the nearest multiple of level_step (ties to even,
// clipped at 255). A ring line store of edge_distance lines delays the image, so
// the pixel taken at (y,x) releases the pixel at (y-E,x); an interior pixel goes
// black when it differs from the quantized pixel E to the right or E below,
// otherwise white in mono mode or its own quantized color. At frame end the
// source sends min(E,H)*W flush transfers (tuser=1) to drain the held lines;
// the last drained pixel carries tlast. The back end takes a pixel in three steps:
// it pops the command queue and issues the line store reads, runs the bit-serial
// quantizer divide, then makes the outline decision and store write; a flush skips
// the divide and the store write. The decision step of an emitting command stretches
// while the output register holds a result that has not been taken. The front end
// and a 4-entry command queue keep the input side taking transfers, until the queue
// is full, while the back end works and while a result waits in the output register.
// Write configuration only while the block is idle; a write takes effect at once.
// Depends on pce_pkg, pce_fifo, pce_front, pce_back.
`timescale 1ns / 1ps
module posterize_edge_cartoon (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in, green_in, red_in
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // blue_out, green_out, red_out
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);
  logic [7:0]    step_r;
  logic [4:0]    edge_r;
  logic          mono_r;
  logic [10:0]   width_r;
  logic [11:0]   height_r;
  pce_pkg::cfg_t cfg;
  pce_pkg::cmd_t push_cmd, head;
  logic          push, pop, empty, full, acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 8'd50;
      edge_r   <= 5'd1;
      mono_r   <= 1'b0;
      width_r  <= 11'd640;
      height_r <= 12'd480;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pce_pkg::REG_LEVEL_STEP:    step_r   <= cfg_wdata[7:0];
        pce_pkg::REG_EDGE_DISTANCE: edge_r   <= cfg_wdata[4:0];
        pce_pkg::REG_MONO_MODE:     mono_r   <= cfg_wdata[0];
        pce_pkg::REG_FRAME_WIDTH:   width_r  <= cfg_wdata[10:0];
        pce_pkg::REG_FRAME_HEIGHT:  height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    cfg.step   = (step_r == '0) ? 8'd1 : step_r;
    cfg.edge_d = (edge_r == '0) ? 5'd1
               : (edge_r > 5'(pce_pkg::MAX_EDGE)) ? 5'(pce_pkg::MAX_EDGE) : edge_r;
    cfg.mono   = mono_r;
    cfg.width  = (width_r == '0) ? 11'd1
               : (width_r > 11'(pce_pkg::MAX_WIDTH)) ? 11'(pce_pkg::MAX_WIDTH) : width_r;
    cfg.height = (height_r == '0) ? 12'd1 : height_r;
  end

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  pce_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .acc(acc), .kind(in_tuser),
    .pix(in_tdata), .push(push), .cmd(push_cmd)
  );

  pce_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
    .head(head), .empty(empty), .full(full)
  );

  pce_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .head(head), .empty(empty), .pop(pop),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .out_last(out_tlast)
  );
endmodule

[rtl/core/pce_checker.sv]
// Port-level checks for posterize_edge_cartoon, bound to the top level.
// Depends on posterize_edge_cartoon_macros.svh.
`timescale 1ns / 1ps
`include "posterize_edge_cartoon_macros.svh"
module pce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready
);
  // a stalled result stays offered
  `PCE_CHK_NEXT_RUN(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // reset empties the output register
  `PCE_CHK_NEXT(a_rst_out, !rst_n, !out_tvalid)
  // reset empties the command queue, so input is taken at once
  `PCE_CHK_NEXT(a_rst_in, !rst_n, in_tready)
endmodule

bind posterize_edge_cartoon pce_checker u_pce_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready)
);
